@@ hw/rtl/ngi_pkg.sv @@
// ============================================================================
// ngi_pkg: shared types and constants of the n-body gravity integrator
// Transaction payloads, the divide/square-root handshake and saturation helpers.
// ============================================================================
package ngi_pkg;

    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_ATTR   = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_UPDATE = 3'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SKIP  = 2'd1;
    localparam logic [1:0] ST_ZMASS = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic [1:0] CFG_GRAV = 2'd0;
    localparam logic [1:0] CFG_DT   = 2'd1;

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = 6;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;
    localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]         command;
        logic [5:0]         body_index;
        logic [5:0]         source_index;
        logic signed [31:0] in_pos_x;
        logic signed [31:0] in_pos_y;
        logic signed [31:0] in_vel_x;
        logic signed [31:0] in_vel_y;
        logic [31:0]        in_mass;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_force_x;
        logic signed [31:0] out_force_y;
        logic [31:0]        out_mass;
    } out_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic [31:0]        mass;
    } body_t;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } du_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } du_rsp_t;

    typedef struct packed {
        logic        clamp;
        logic [31:0] value;
    } sat_t;

    function automatic logic [65:0] sext66(input logic [31:0] v);
        sext66 = {{34{v[31]}}, v};
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        abs32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    // clamp a two's complement value to 32-bit signed
    function automatic sat_t sat_s32(input logic [65:0] v);
        sat_t r;
        if ((&v[65:31]) || (~|v[65:31])) begin
            r.clamp = 1'b0;
            r.value = v[31:0];
        end else begin
            r.clamp = 1'b1;
            r.value = v[65] ? S32_MIN : S32_MAX;
        end
        sat_s32 = r;
    endfunction

endpackage

@@ hw/rtl/ngi_divsqrt.sv @@
// ============================================================================
// ngi_divsqrt: iterative divider and square root
// Restoring 64/32 divide or 64-bit integer square root, one bit per cycle.
// ============================================================================
module ngi_divsqrt
    import ngi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  du_req_t     req,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output du_rsp_t     rsp,
    output logic [63:0] result
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             mode_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [63:0]      acc_reg;
    logic [34:0]      rem_reg;
    logic [63:0]      quo_reg;
    logic [31:0]      den_reg;

    logic [35:0] div_trial;
    logic [35:0] div_diff;
    logic [35:0] sq_r;
    logic [35:0] sq_trial;
    logic [35:0] sq_diff;
    logic        ge;

    assign div_trial = {3'b0, rem_reg[31:0], acc_reg[63]};
    assign div_diff  = div_trial - {4'b0, den_reg};
    assign sq_r      = {1'b0, rem_reg[32:0], acc_reg[63:62]};
    assign sq_trial  = {2'b0, quo_reg[31:0], 2'b01};
    assign sq_diff   = sq_r - sq_trial;
    assign ge        = mode_reg ? ~sq_diff[35] : ~div_diff[35];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
        end else if (busy_reg && (cnt_reg == '0)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start) begin
            mode_reg <= req.sqrt_mode;
            cnt_reg  <= req.sqrt_mode ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
            acc_reg  <= num;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= den;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            quo_reg <= {quo_reg[62:0], ge};
            if (mode_reg) begin
                acc_reg <= {acc_reg[61:0], 2'b00};
                rem_reg <= ge ? sq_diff[34:0] : sq_r[34:0];
            end else begin
                acc_reg <= {acc_reg[62:0], 1'b0};
                rem_reg <= ge ? div_diff[34:0] : div_trial[34:0];
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = quo_reg;

endmodule

@@ hw/rtl/nbody_gravity_integrator_unit.sv @@
// ============================================================================
// nbody_gravity_integrator_unit: fixed-point n-body force and integration
// Body table with load, read, clear force, update and attraction commands.
// ============================================================================
// One command is taken at a time; in_ready stays low until its result is
// registered. Load, read and clear pass through the body table only, update
// adds two divides and attraction a square root and four divides, all in the
// one-bit-per-cycle divide/square-root unit; products come from a shared 33x33
// registered multiplier. After reset a clearing pass zeroes every entry of the
// body table before the first command is taken. Configuration writes are
// always accepted.
module nbody_gravity_integrator_unit
    import ngi_pkg::*;
#(
    parameter int MAX_BODIES = 64,
    parameter int FRAC_BITS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W  = $clog2(MAX_BODIES);
    localparam int IDXR_W = (IDX_W > 6) ? IDX_W : 6;
    localparam logic [IDXR_W:0] MAX_V = (IDXR_W + 1)'(MAX_BODIES);

    typedef enum logic [30:0] {
        S_CLEAR    = 31'h0000_0001,
        S_IDLE     = 31'h0000_0002,
        S_IDX      = 31'h0000_0004,
        S_RD_T     = 31'h0000_0008,
        S_RD_S     = 31'h0000_0010,
        S_WR       = 31'h0000_0020,
        S_OUT      = 31'h0000_0040,
        U_DIV_GO   = 31'h0000_0080,
        U_DIV_WAIT = 31'h0000_0100,
        U_MUL1     = 31'h0000_0200,
        U_V        = 31'h0000_0400,
        U_AVG      = 31'h0000_0800,
        U_MUL2     = 31'h0000_1000,
        U_P        = 31'h0000_2000,
        A_DX       = 31'h0000_4000,
        A_M1       = 31'h0000_8000,
        A_M2       = 31'h0001_0000,
        A_M3       = 31'h0002_0000,
        A_CHK      = 31'h0004_0000,
        A_SQ_WAIT  = 31'h0008_0000,
        A_P1       = 31'h0010_0000,
        A_P2       = 31'h0020_0000,
        A_Q1       = 31'h0040_0000,
        A_Q2       = 31'h0080_0000,
        A_TQ_GO    = 31'h0100_0000,
        A_TQ_WAIT  = 31'h0200_0000,
        A_MG_GO    = 31'h0400_0000,
        A_MG_WAIT  = 31'h0800_0000,
        A_FM       = 31'h1000_0000,
        A_FC_GO    = 31'h2000_0000,
        A_FC_WAIT  = 31'h4000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       grav_reg;
    logic [15:0]       dt_reg;

    logic [2:0]        cmd_reg, cmd_next;
    logic [IDXR_W-1:0] tgt_reg, tgt_next;
    logic [IDXR_W-1:0] src_reg, src_next;
    in_t               load_reg, load_next;
    body_t             body_reg, body_next;
    logic [31:0]       src_mass_reg, src_mass_next;
    logic              dx_neg_reg, dx_neg_next;
    logic              dy_neg_reg, dy_neg_next;
    logic [31:0]       ux_reg, ux_next;
    logic [31:0]       uy_reg, uy_next;
    logic [63:0]       d2_reg, d2_next;
    logic [31:0]       d_reg, d_next;
    logic [31:0]       t_reg, t_next;
    logic [31:0]       mag_reg, mag_next;
    logic [31:0]       a_reg, a_next;
    logic [31:0]       vnew_reg, vnew_next;
    logic [31:0]       avg_reg, avg_next;
    logic              axis_reg, axis_next;
    logic              flag_reg, flag_next;
    logic [1:0]        status_reg, status_next;
    out_t              out_data_reg, out_data_next;
    logic [65:0]       prod_reg;

    body_t             body_mem [MAX_BODIES];
    body_t             rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  mem_waddr;
    body_t             mem_wdata;
    logic              mem_we;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;

    du_req_t     du_req;
    du_rsp_t     du_rsp;
    logic [63:0] du_num;
    logic [31:0] du_den;
    logic [63:0] du_result;

    // per-axis views and datapath
    logic [31:0] f_axis, v_axis, p_axis, u_axis;
    logic        neg_axis;
    logic [63:0] am;
    logic        am_over;
    logic [31:0] am_val;
    sat_t        vsum;
    logic [32:0] vpair;
    logic [32:0] vpair_adj;
    sat_t        psum;
    logic [32:0] dx_diff, dy_diff;
    sat_t        dx_sat, dy_sat;
    logic [63:0] prod_shift;
    logic        prod_over;
    logic [31:0] prod_cap;
    logic [63:0] num_shift;
    logic [65:0] f_add;
    sat_t        fsum;

    assign f_axis   = axis_reg ? body_reg.force_y : body_reg.force_x;
    assign v_axis   = axis_reg ? body_reg.vel_y : body_reg.vel_x;
    assign p_axis   = axis_reg ? body_reg.pos_y : body_reg.pos_x;
    assign u_axis   = axis_reg ? uy_reg : ux_reg;
    assign neg_axis = axis_reg ? dy_neg_reg : dx_neg_reg;

    assign am      = du_result;
    assign am_over = f_axis[31] ? ((am[63:32] != '0) || (am[31] && (am[30:0] != '0)))
                                : (am[63:31] != '0);
    assign am_val  = f_axis[31] ? (am_over ? S32_MIN : (~am[31:0] + 32'd1))
                                : (am_over ? S32_MAX : am[31:0]);

    assign vsum      = sat_s32(sext66(v_axis) + prod_reg);
    assign vpair     = {v_axis[31], v_axis} + {vnew_reg[31], vnew_reg};
    // bias negative sums so the halving truncates toward zero
    assign vpair_adj = vpair + {32'b0, vpair[32]};
    assign psum      = sat_s32(sext66(p_axis) + prod_reg);

    assign dx_diff = {rd_data_reg.pos_x[31], rd_data_reg.pos_x}
                   - {body_reg.pos_x[31], body_reg.pos_x};
    assign dy_diff = {rd_data_reg.pos_y[31], rd_data_reg.pos_y}
                   - {body_reg.pos_y[31], body_reg.pos_y};
    assign dx_sat  = sat_s32({{33{dx_diff[32]}}, dx_diff});
    assign dy_sat  = sat_s32({{33{dy_diff[32]}}, dy_diff});

    assign prod_shift = prod_reg[63:0] >> FRAC_BITS;
    assign prod_over  = prod_shift[63:32] != '0;
    assign prod_cap   = prod_over ? U32_MAX : prod_shift[31:0];

    assign num_shift = {32'b0, t_reg} << FRAC_BITS;

    assign f_add = neg_axis ? (66'd0 - {34'b0, du_result[31:0]}) : {34'b0, du_result[31:0]};
    assign fsum  = sat_s32(sext66(f_axis) + f_add);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            U_MUL1:
            begin
                mul_a = {a_reg[31], a_reg};
                mul_b = {17'b0, dt_reg};
            end
            U_MUL2:
            begin
                mul_a = {avg_reg[31], avg_reg};
                mul_b = {17'b0, dt_reg};
            end
            A_M1:
            begin
                mul_a = {1'b0, ux_reg};
                mul_b = {1'b0, ux_reg};
            end
            A_M2:
            begin
                mul_a = {1'b0, uy_reg};
                mul_b = {1'b0, uy_reg};
            end
            A_P1:
            begin
                mul_a = {1'b0, grav_reg};
                mul_b = {1'b0, src_mass_reg};
            end
            A_Q1:
            begin
                mul_a = {1'b0, t_reg};
                mul_b = {1'b0, body_reg.mass};
            end
            A_FM:
            begin
                mul_a = {1'b0, mag_reg};
                mul_b = {1'b0, u_axis};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(mul_a * mul_b);
    end

    // divide / square-root requests
    always_comb
    begin
        du_req.start     = 1'b0;
        du_req.sqrt_mode = 1'b0;
        du_num           = '0;
        du_den           = d_reg;
        unique case (state_reg)
            U_DIV_GO:
            begin
                du_req.start = 1'b1;
                du_num       = {32'b0, abs32(f_axis)} << FRAC_BITS;
                du_den       = body_reg.mass;
            end
            A_CHK:
            begin
                du_req.start     = (d2_reg != '0);
                du_req.sqrt_mode = 1'b1;
                du_num           = d2_reg;
            end
            A_TQ_GO, A_MG_GO:
            begin
                du_req.start = 1'b1;
                du_num       = num_shift;
            end
            A_FC_GO:
            begin
                du_req.start = 1'b1;
                du_num       = prod_reg[63:0];
            end
            default:
            begin
                du_req.start = 1'b0;
            end
        endcase
    end

    ngi_divsqrt u_divsqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (du_req),
        .num    (du_num),
        .den    (du_den),
        .rsp    (du_rsp),
        .result (du_result)
    );

    // body table
    assign rd_addr   = (state_reg == S_RD_S) ? src_reg[IDX_W-1:0] : tgt_reg[IDX_W-1:0];
    assign mem_we    = (state_reg == S_CLEAR) || (state_reg == S_WR);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_reg : tgt_reg[IDX_W-1:0];
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : body_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            body_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= body_mem[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        tgt_next       = tgt_reg;
        src_next       = src_reg;
        load_next      = load_reg;
        body_next      = body_reg;
        src_mass_next  = src_mass_reg;
        dx_neg_next    = dx_neg_reg;
        dy_neg_next    = dy_neg_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        d2_next        = d2_reg;
        d_next         = d_reg;
        t_next         = t_reg;
        mag_next       = mag_reg;
        a_next         = a_reg;
        vnew_next      = vnew_reg;
        avg_next       = avg_reg;
        axis_next      = axis_reg;
        flag_next      = flag_reg;
        status_next    = status_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(MAX_BODIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd_next   = in_data.command;
                    tgt_next   = IDXR_W'(in_data.body_index);
                    src_next   = IDXR_W'(in_data.source_index);
                    load_next  = in_data;
                    state_next = S_IDX;
                end
            end
            S_IDX:
            begin
                // reduce both indices modulo the table depth
                if ({1'b0, tgt_reg} >= MAX_V) begin
                    tgt_next = IDXR_W'({1'b0, tgt_reg} - MAX_V);
                end
                if ({1'b0, src_reg} >= MAX_V) begin
                    src_next = IDXR_W'({1'b0, src_reg} - MAX_V);
                end
                if (({1'b0, tgt_reg} < MAX_V) && ({1'b0, src_reg} < MAX_V)) begin
                    state_next = S_RD_T;
                end
            end
            S_RD_T:
            begin
                state_next = S_RD_S;
            end
            S_RD_S:
            begin
                body_next   = rd_data_reg;
                status_next = ST_OK;
                flag_next   = 1'b0;
                axis_next   = 1'b0;
                state_next  = S_WR;
                unique case (cmd_reg)
                    CMD_LOAD:
                    begin
                        body_next.pos_x   = load_reg.in_pos_x;
                        body_next.pos_y   = load_reg.in_pos_y;
                        body_next.vel_x   = load_reg.in_vel_x;
                        body_next.vel_y   = load_reg.in_vel_y;
                        body_next.mass    = load_reg.in_mass;
                        body_next.force_x = '0;
                        body_next.force_y = '0;
                    end
                    CMD_ATTR:
                    begin
                        if (tgt_reg == src_reg) begin
                            status_next = ST_SKIP;
                        end else begin
                            state_next = A_DX;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        body_next.force_x = '0;
                        body_next.force_y = '0;
                    end
                    CMD_UPDATE:
                    begin
                        if (rd_data_reg.mass == '0) begin
                            status_next = ST_ZMASS;
                        end else begin
                            state_next = U_DIV_GO;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_WR:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready) begin
                    out_data_next.status      = flag_reg ? ST_SAT : status_reg;
                    out_data_next.out_pos_x   = body_reg.pos_x;
                    out_data_next.out_pos_y   = body_reg.pos_y;
                    out_data_next.out_vel_x   = body_reg.vel_x;
                    out_data_next.out_vel_y   = body_reg.vel_y;
                    out_data_next.out_force_x = body_reg.force_x;
                    out_data_next.out_force_y = body_reg.force_y;
                    out_data_next.out_mass    = body_reg.mass;
                    out_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            U_DIV_GO:
            begin
                state_next = U_DIV_WAIT;
            end
            U_DIV_WAIT:
            begin
                if (du_rsp.done) begin
                    a_next     = am_val;
                    flag_next  = flag_reg | am_over;
                    state_next = U_MUL1;
                end
            end
            U_MUL1:
            begin
                state_next = U_V;
            end
            U_V:
            begin
                vnew_next  = vsum.value;
                flag_next  = flag_reg | vsum.clamp;
                state_next = U_AVG;
            end
            U_AVG:
            begin
                avg_next = vpair_adj[32:1];
                if (axis_reg) begin
                    body_next.vel_y = vnew_reg;
                end else begin
                    body_next.vel_x = vnew_reg;
                end
                state_next = U_MUL2;
            end
            U_MUL2:
            begin
                state_next = U_P;
            end
            U_P:
            begin
                flag_next = flag_reg | psum.clamp;
                if (axis_reg) begin
                    body_next.pos_y = psum.value;
                    state_next      = S_WR;
                end else begin
                    body_next.pos_x = psum.value;
                    axis_next       = 1'b1;
                    state_next      = U_DIV_GO;
                end
            end
            A_DX:
            begin
                src_mass_next = rd_data_reg.mass;
                dx_neg_next   = dx_sat.value[31];
                dy_neg_next   = dy_sat.value[31];
                ux_next       = abs32(dx_sat.value);
                uy_next       = abs32(dy_sat.value);
                flag_next     = flag_reg | dx_sat.clamp | dy_sat.clamp;
                state_next    = A_M1;
            end
            A_M1:
            begin
                state_next = A_M2;
            end
            A_M2:
            begin
                d2_next    = prod_reg[63:0];
                state_next = A_M3;
            end
            A_M3:
            begin
                d2_next    = d2_reg + prod_reg[63:0];
                state_next = A_CHK;
            end
            A_CHK:
            begin
                if (d2_reg == '0) begin
                    status_next = ST_SKIP;
                    flag_next   = 1'b0;
                    state_next  = S_WR;
                end else begin
                    state_next = A_SQ_WAIT;
                end
            end
            A_SQ_WAIT:
            begin
                if (du_rsp.done) begin
                    d_next     = du_result[31:0];
                    state_next = A_P1;
                end
            end
            A_P1:
            begin
                state_next = A_P2;
            end
            A_P2:
            begin
                t_next     = prod_cap;
                flag_next  = flag_reg | prod_over;
                state_next = A_Q1;
            end
            A_Q1:
            begin
                state_next = A_Q2;
            end
            A_Q2:
            begin
                t_next     = prod_cap;
                flag_next  = flag_reg | prod_over;
                state_next = A_TQ_GO;
            end
            A_TQ_GO:
            begin
                state_next = A_TQ_WAIT;
            end
            A_TQ_WAIT:
            begin
                if (du_rsp.done) begin
                    t_next     = (du_result[63:32] != '0) ? U32_MAX : du_result[31:0];
                    flag_next  = flag_reg | (du_result[63:32] != '0);
                    state_next = A_MG_GO;
                end
            end
            A_MG_GO:
            begin
                state_next = A_MG_WAIT;
            end
            A_MG_WAIT:
            begin
                if (du_rsp.done) begin
                    mag_next   = (du_result[63:31] != '0) ? S32_MAX : du_result[31:0];
                    flag_next  = flag_reg | (du_result[63:31] != '0);
                    axis_next  = 1'b0;
                    state_next = A_FM;
                end
            end
            A_FM:
            begin
                state_next = A_FC_GO;
            end
            A_FC_GO:
            begin
                state_next = A_FC_WAIT;
            end
            A_FC_WAIT:
            begin
                if (du_rsp.done) begin
                    flag_next = flag_reg | fsum.clamp;
                    if (axis_reg) begin
                        body_next.force_y = fsum.value;
                        state_next        = S_WR;
                    end else begin
                        body_next.force_x = fsum.value;
                        axis_next         = 1'b1;
                        state_next        = A_FM;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            grav_reg      <= 32'h0001_0000;
            dt_reg        <= 16'd1;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_GRAV: grav_reg <= cfg_data;
                    CFG_DT:   dt_reg   <= cfg_data[15:0];
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        tgt_reg      <= tgt_next;
        src_reg      <= src_next;
        load_reg     <= load_next;
        body_reg     <= body_next;
        src_mass_reg <= src_mass_next;
        dx_neg_reg   <= dx_neg_next;
        dy_neg_reg   <= dy_neg_next;
        ux_reg       <= ux_next;
        uy_reg       <= uy_next;
        d2_reg       <= d2_next;
        d_reg        <= d_next;
        t_reg        <= t_next;
        mag_reg      <= mag_next;
        a_reg        <= a_next;
        vnew_reg     <= vnew_next;
        avg_reg      <= avg_next;
        axis_reg     <= axis_next;
        flag_reg     <= flag_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        du_req.start |-> !du_rsp.busy)
        else $error("divide/sqrt started while busy");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after an input transaction");

    a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_WR))
        else $error("body table written outside clear or write-back");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        du_rsp.done |-> $past(du_rsp.busy))
        else $error("divide/sqrt done without a running operation");
`endif

endmodule

@@ sim/tb.sv @@
// ============================================================================
// tb: testbench of nbody_gravity_integrator_unit
// Drives load, attraction, clear, update and read commands through the command
// channel under random idling, predicts each body record in a local copy of the
// body table and checks every result field, across several G and dt settings.
// ============================================================================
module tb;
    import ngi_pkg::*;

    localparam logic [2:0] CMD_READ = 3'd4;
    localparam logic [2:0] CMD_LAST = 3'd7;
    localparam int NB = 64;
    localparam int FB = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam longint unsigned U32 = 64'hFFFF_FFFF;
    localparam longint S32HI = 64'sd2147483647;
    localparam longint S32LO = -64'sd2147483648;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_t        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // predicted body table and configuration
    longint          tbl_px [NB];
    longint          tbl_py [NB];
    longint          tbl_vx [NB];
    longint          tbl_vy [NB];
    longint          tbl_fx [NB];
    longint          tbl_fy [NB];
    longint unsigned tbl_m  [NB];
    longint unsigned grav_g = 65536;
    longint          step_dt = 1;

    in_t  cmd_queue[$];
    out_t expected_bodies[$];
    int   live_bodies[$];
    bit   loaded [NB];
    int   errors = 0;
    int   results_checked = 0;
    int   cmd_count [8];
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   hold_ask = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   idle_cycles = 0;

    nbody_gravity_integrator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_s32(input longint v, inout bit fl);
        if (v > S32HI)
        begin
            fl = 1'b1;
            return S32HI;
        end
        if (v < S32LO)
        begin
            fl = 1'b1;
            return S32LO;
        end
        return v;
    endfunction

    function automatic longint unsigned clamp_u(input longint unsigned v,
                                                input longint unsigned lim, inout bit fl);
        if (v > lim)
        begin
            fl = 1'b1;
            return lim;
        end
        return v;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint with_sign(input longint unsigned m, input bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // a = F/m, v' = v + a*dt, p' = p + mean(v, v')*dt
    function automatic void integrate_axis(inout longint p, inout longint v, input longint f,
                                           input longint unsigned m, inout bit fl);
        longint unsigned am;
        longint a;
        longint vnew;
        longint avg;
        am = (magnitude(f) << FB) / m;
        a = clamp_s32(with_sign(am, f < 0), fl);
        vnew = clamp_s32(v + a * step_dt, fl);
        avg = (v + vnew) / 2;
        v = vnew;
        p = clamp_s32(p + avg * step_dt, fl);
    endfunction

    function automatic logic [1:0] add_pull(input int t, input int s);
        bit fl;
        longint dx;
        longint dy;
        longint unsigned ux, uy, d2, d, p, q, tq, mag;
        fl = 1'b0;
        if (t == s)
            return ST_SKIP;
        dx = clamp_s32(tbl_px[s] - tbl_px[t], fl);
        dy = clamp_s32(tbl_py[s] - tbl_py[t], fl);
        ux = magnitude(dx);
        uy = magnitude(dy);
        d2 = ux * ux + uy * uy;
        if (d2 == 0)
            return ST_SKIP;
        d = int_sqrt(d2);
        p = clamp_u((grav_g * tbl_m[s]) >> FB, U32, fl);
        q = clamp_u((p * tbl_m[t]) >> FB, U32, fl);
        tq = clamp_u((q << FB) / d, U32, fl);
        mag = clamp_u((tq << FB) / d, longint'(S32HI), fl);
        tbl_fx[t] = clamp_s32(tbl_fx[t] + with_sign(mag * ux / d, dx < 0), fl);
        tbl_fy[t] = clamp_s32(tbl_fy[t] + with_sign(mag * uy / d, dy < 0), fl);
        return fl ? ST_SAT : ST_OK;
    endfunction

    function automatic out_t predict_body_record(input in_t c);
        out_t e;
        int b;
        bit fl;
        b = c.body_index;
        fl = 1'b0;
        e.status = ST_OK;
        case (c.command)
            CMD_LOAD:
            begin
                tbl_px[b] = c.in_pos_x;
                tbl_py[b] = c.in_pos_y;
                tbl_vx[b] = c.in_vel_x;
                tbl_vy[b] = c.in_vel_y;
                tbl_m[b] = c.in_mass;
                tbl_fx[b] = 0;
                tbl_fy[b] = 0;
            end
            CMD_ATTR:
                e.status = add_pull(b, c.source_index);
            CMD_CLEAR:
            begin
                tbl_fx[b] = 0;
                tbl_fy[b] = 0;
            end
            CMD_UPDATE:
            begin
                if (tbl_m[b] == 0)
                    e.status = ST_ZMASS;
                else
                begin
                    integrate_axis(tbl_px[b], tbl_vx[b], tbl_fx[b], tbl_m[b], fl);
                    integrate_axis(tbl_py[b], tbl_vy[b], tbl_fy[b], tbl_m[b], fl);
                    e.status = fl ? ST_SAT : ST_OK;
                end
            end
            default: ;
        endcase
        e.out_pos_x = tbl_px[b][31:0];
        e.out_pos_y = tbl_py[b][31:0];
        e.out_vel_x = tbl_vx[b][31:0];
        e.out_vel_y = tbl_vy[b][31:0];
        e.out_force_x = tbl_fx[b][31:0];
        e.out_force_y = tbl_fy[b][31:0];
        e.out_mass = tbl_m[b][31:0];
        return e;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("MISMATCH result %0d %s: got %h expected %h", results_checked, field, got, want);
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic nv;
        in_t  nd;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            nv = in_valid;
            nd = in_data;
            if (in_valid && in_ready)
            begin
                expected_bodies.push_back(predict_body_record(in_data));
                cmd_count[in_data.command]++;
                nv = 1'b0;
            end
            if (!nv && cmd_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                nd = cmd_queue.pop_front();
                nv = 1'b1;
            end
            in_valid <= nv;
            in_data <= nd;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_t e;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bodies.size() == 0)
                begin
                    report_mismatch("unexpected transaction", out_data.out_pos_x, '0);
                end
                else
                begin
                    e = expected_bodies.pop_front();
                    check_field("status", 32'(out_data.status), 32'(e.status));
                    check_field("pos_x", out_data.out_pos_x, e.out_pos_x);
                    check_field("pos_y", out_data.out_pos_y, e.out_pos_y);
                    check_field("vel_x", out_data.out_vel_x, e.out_vel_x);
                    check_field("vel_y", out_data.out_vel_y, e.out_vel_y);
                    check_field("force_x", out_data.out_force_x, e.out_force_x);
                    check_field("force_y", out_data.out_force_y, e.out_force_y);
                    check_field("mass", out_data.out_mass, e.out_mass);
                    results_checked++;
                end
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (hold_seen != hold_ask)
            begin
                hold_seen <= hold_ask;
                hold_left <= RX_HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return S32_MAX;
            1: return S32_MIN;
            2: return $urandom();
            default: return 32'($urandom_range(32'h00C8_0000)) - 32'h0064_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(19))
            0: return 32'd0;
            1: return U32_MAX;
            2, 3: return $urandom();
            default: return 32'h0001_0000 + 32'($urandom_range(32'h0014_0000));
        endcase
    endfunction

    function automatic in_t make_cmd(input logic [2:0] op, input int b, input int s);
        in_t c;
        c.command = op;
        c.body_index = 6'(b);
        c.source_index = 6'(s);
        c.in_pos_x = pick_coord();
        c.in_pos_y = pick_coord();
        c.in_vel_x = pick_coord();
        c.in_vel_y = pick_coord();
        c.in_mass = pick_mass();
        if (op == CMD_LOAD && !loaded[b])
        begin
            loaded[b] = 1'b1;
            live_bodies.push_back(b);
        end
        return c;
    endfunction

    function automatic int any_live();
        return live_bodies[$urandom_range(live_bodies.size() - 1)];
    endfunction

    function automatic in_t random_cmd();
        int r;
        int t;
        int s;
        r = $urandom_range(99);
        if (live_bodies.size() < 2 || r < 15)
            return make_cmd(CMD_LOAD, $urandom_range(NB - 1), $urandom_range(NB - 1));
        t = any_live();
        if (r < 55)
        begin
            s = ($urandom_range(19) == 0) ? t : any_live();
            return make_cmd(CMD_ATTR, t, s);
        end
        if (r < 78)
            return make_cmd(CMD_UPDATE, t, $urandom_range(NB - 1));
        if (r < 86)
            return make_cmd(CMD_CLEAR, t, $urandom_range(NB - 1));
        if (r < 95)
            return make_cmd(CMD_READ, t, $urandom_range(NB - 1));
        return make_cmd(3'($urandom_range(CMD_READ + 1, CMD_LAST)), t, $urandom_range(NB - 1));
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_GRAV)
            grav_g = val;
        else
            step_dt = val[15:0];
    endtask

    // hold until every queued command has produced its result
    task automatic drain();
        @(negedge clk);
        while (cmd_queue.size() > 0 || in_valid || expected_bodies.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        in_t c;
        for (int i = 0; i < NB; i++)
        begin
            tbl_px[i] = 0; tbl_py[i] = 0; tbl_vx[i] = 0; tbl_vy[i] = 0;
            tbl_fx[i] = 0; tbl_fy[i] = 0; tbl_m[i] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every command, skip and zero-mass cases
        tx_idle_pct = 25;
        rx_idle_pct = 85;
        c = make_cmd(CMD_LOAD, 0, 0);
        c.in_pos_x = S32_MAX; c.in_pos_y = S32_MAX; c.in_mass = U32_MAX;
        cmd_queue.push_back(c);
        c = make_cmd(CMD_LOAD, 63, 63);
        c.in_pos_x = S32_MIN; c.in_pos_y = S32_MIN; c.in_vel_x = S32_MIN;
        c.in_mass = U32_MAX;
        cmd_queue.push_back(c);
        c = make_cmd(CMD_LOAD, 1, 0);
        c.in_pos_x = S32_MAX; c.in_pos_y = S32_MAX; c.in_mass = 32'h0001_0000;
        cmd_queue.push_back(c);
        c = make_cmd(CMD_LOAD, 2, 0);
        c.in_mass = 32'd0;
        cmd_queue.push_back(c);
        c = make_cmd(CMD_LOAD, 3, 0);
        c.in_pos_x = 32'h0000_0000; c.in_pos_y = 32'h0000_0000; c.in_vel_x = 32'h0001_0000;
        c.in_vel_y = 32'hFFFF_0000; c.in_mass = 32'h0002_0000;
        cmd_queue.push_back(c);
        c = make_cmd(CMD_LOAD, 4, 0);
        c.in_pos_x = 32'h0003_0000; c.in_pos_y = 32'hFFFC_0000; c.in_vel_x = 32'h0;
        c.in_vel_y = 32'h0; c.in_mass = 32'h0005_0000;
        cmd_queue.push_back(c);
        cmd_queue.push_back(make_cmd(CMD_ATTR, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_ATTR, 1, 0));
        cmd_queue.push_back(make_cmd(CMD_ATTR, 63, 0));
        cmd_queue.push_back(make_cmd(CMD_ATTR, 0, 63));
        cmd_queue.push_back(make_cmd(CMD_UPDATE, 63, 0));
        cmd_queue.push_back(make_cmd(CMD_UPDATE, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_UPDATE, 2, 0));
        cmd_queue.push_back(make_cmd(CMD_ATTR, 3, 4));
        cmd_queue.push_back(make_cmd(CMD_ATTR, 4, 3));
        cmd_queue.push_back(make_cmd(CMD_ATTR, 3, 4));
        cmd_queue.push_back(make_cmd(CMD_UPDATE, 3, 0));
        cmd_queue.push_back(make_cmd(CMD_UPDATE, 4, 0));
        cmd_queue.push_back(make_cmd(CMD_CLEAR, 63, 0));
        cmd_queue.push_back(make_cmd(CMD_READ, 63, 0));
        cmd_queue.push_back(make_cmd(CMD_LAST, 1, 63));
        cmd_queue.push_back(make_cmd(3'd5, 4, 0));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph / 2)
                0: begin tx_idle_pct = 25; rx_idle_pct = 85; end
                1: begin tx_idle_pct = 85; rx_idle_pct = 25; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            case (ph)
                1: begin write_reg(CFG_GRAV, U32_MAX); write_reg(CFG_DT, 32'h0000_FFFF); end
                2: begin write_reg(CFG_GRAV, 32'd0); write_reg(CFG_DT, 32'd0); end
                3: begin write_reg(CFG_GRAV, $urandom()); write_reg(CFG_DT, $urandom_range(1, 8)); end
                4: begin write_reg(CFG_GRAV, 32'h0001_0000); write_reg(CFG_DT, $urandom_range(65535)); end
                5: begin write_reg(CFG_GRAV, $urandom_range(32'h0010_0000)); write_reg(CFG_DT, 32'd3); end
                default: ;
            endcase
            if (ph == 5)
                hold_ask++;
            for (int half = 0; half < 2; half++)
            begin
                for (int k = 0; k < 52; k++)
                    cmd_queue.push_back(random_cmd());
                drain();
            end
        end

        repeat (20) @(posedge clk);
        $display("Covered %0d loads, %0d attractions, %0d clears, %0d updates, %0d reads",
                 cmd_count[CMD_LOAD], cmd_count[CMD_ATTR], cmd_count[CMD_CLEAR],
                 cmd_count[CMD_UPDATE], cmd_count[CMD_READ] + cmd_count[5] + cmd_count[6]
                 + cmd_count[7]);
        $display("%0d body records checked over six G/dt settings", results_checked);
        if (errors == 0 && expected_bodies.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
